// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/vsls_pkg.sv -----
// ----------------------------------------------------------------------------
// vsls_pkg
// Types, constants and register codes of the velocity slew limiter.
// ----------------------------------------------------------------------------
package vsls_pkg;

   typedef logic signed [20:0] vel_type;
   typedef logic [47:0]        time_type;

   localparam int LANES = 2;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 20;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_LINEAR_SPEED    = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_LINEAR_SPEED    = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ANGULAR_SPEED   = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_LINEAR_ACCEL    = 4'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ANGULAR_ACCEL   = 4'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINEAR_SMOOTHING    = 4'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGULAR_SMOOTHING   = 4'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLOW_TURN_THRESHOLD = 4'd7;

   // reset values
   localparam logic [19:0] RST_MAX_LINEAR_SPEED    = 20'd32768;
   localparam logic [19:0] RST_MIN_LINEAR_SPEED    = 20'd3277;
   localparam logic [19:0] RST_MAX_ANGULAR_SPEED   = 20'd65536;
   localparam logic [19:0] RST_MAX_LINEAR_ACCEL    = 20'd32768;
   localparam logic [19:0] RST_MAX_ANGULAR_ACCEL   = 20'd65536;
   localparam logic [15:0] RST_LINEAR_SMOOTHING    = 16'd0;
   localparam logic [15:0] RST_ANGULAR_SMOOTHING   = 16'd0;
   localparam logic [19:0] RST_SLOW_TURN_THRESHOLD = 20'd26214;

   // bounds applied to the stored registers
   localparam logic [19:0] FLOOR_MAX_LINEAR_SPEED  = 20'd655;
   localparam logic [19:0] FLOOR_MAX_ANGULAR_SPEED = 20'd6554;
   localparam logic [19:0] FLOOR_MAX_LINEAR_ACCEL  = 20'd3277;
   localparam logic [19:0] FLOOR_MAX_ANGULAR_ACCEL = 20'd6554;
   localparam logic [15:0] CEIL_SMOOTHING          = 16'd64225;

   // elapsed time handling
   localparam logic [47:0] MIN_DT_US     = 48'd1000;
   localparam logic [31:0] DEFAULT_DT_US = 32'd100000;
   // beyond 2^31 us every legal accel already saturates the step
   localparam logic [47:0] DT_CAP_WIDE   = 48'h0000_8000_0000;
   localparam logic [31:0] DT_CAP_US     = 32'h8000_0000;

   // step = accel * dt / 10^6, saturated at 2^22
   localparam logic [51:0] SAT_PRODUCT = 52'd4194305000000;  // (2^22 + 1) * 10^6
   localparam logic [22:0] STEP_CAP    = 23'h40_0000;
   // below saturation: (prod >> 6) * ceil(2^50 / 15625) >> 50, exact for
   // every product under SAT_PRODUCT; the constant 72057594038 is split
   // into an upper part (bits 36:19) and a lower part (bits 18:0)
   localparam logic [18:0] RECIP_HI_PART = 19'd137438;
   localparam logic [18:0] RECIP_LO_PART = 19'd499894;

   // blend and output shaping
   localparam logic [16:0] ONE_Q16    = 17'd65536;
   localparam logic [37:0] ROUND_BIAS = 38'd32768;
   localparam logic [20:0] DEAD_LSB   = 21'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RECIP_LO,
      ST_RECIP_HI,
      ST_LIMIT,
      ST_BLEND,
      ST_FINISH
   } vsls_state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic recip_lo;
      logic recip_hi;
      logic limit;
      logic blend;
      logic load_out;
   } vsls_cmd_type;

   // effective configuration, bounds already applied
   typedef struct packed {
      logic [19:0] vmax_l;
      logic [19:0] vmin_l;
      logic [19:0] vmax_a;
      logic [19:0] acc_l;
      logic [19:0] acc_a;
      logic [15:0] sm_l;
      logic [15:0] sm_a;
      logic [19:0] slow_turn;
   } vsls_cfg_type;

endpackage

// ----- rtl/core/vsls_ifs.sv -----
// ----------------------------------------------------------------------------
// vsls channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vsls_req_if import vsls_pkg::*; ;
   logic     valid;
   logic     ready;
   vel_type  linear_request;
   vel_type  angular_request;
   time_type time_us;

   modport source (output valid, output linear_request, output angular_request,
                   output time_us, input ready);
   modport sink   (input valid, input linear_request, input angular_request,
                   input time_us, output ready);
endinterface

interface vsls_rsp_if import vsls_pkg::*; ;
   logic    valid;
   logic    ready;
   vel_type linear_cmd;
   vel_type angular_cmd;

   modport source (output valid, output linear_cmd, output angular_cmd, input ready);
   modport sink   (input valid, input linear_cmd, input angular_cmd, output ready);
endinterface

// ----- rtl/core/velocity_slew_limit_smoother_top.sv -----
// ----------------------------------------------------------------------------
// velocity_slew_limit_smoother_top
// Slew-rate limiter with exponential smoothing for linear/angular commands.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-------------------------------
//   req_ch  | in        | valid/ready          | linear_request, angular_request,
//           |           |                      | time_us
//   rsp_ch  | out       | valid/ready          | linear_cmd, angular_cmd
//   csr_*   | in        | write enable, no ack | index (4 bits), data (20 bits)
//
// One word is in flight at a time: an accepted word steps through multiply,
// two reciprocal halves, limit, blend and finish before the next is accepted.
// The step limit takes one multiply of accel by dt and two halves of
// reciprocal multiply for the divide by 10^6; both channels work side by side.
// Reset is synchronous: it restores the register defaults and clears the last
// command, last timestamp and output valid.
// A result waits in the output register while the next word is accepted and
// worked on; the finish step holds until that result has been taken, so an
// output stall longer than the work on the next word stretches the turnaround.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module velocity_slew_limit_smoother_top import vsls_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   vsls_req_if.sink                   req_ch,
   vsls_rsp_if.source                 rsp_ch,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   vsls_cfg_type    cfg;
   vsls_cmd_type    cmd;

   // register file: stored values and their bounded, effective forms
   vsls_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   // sequencer: owns both handshakes and issues one command a cycle unless waiting in idle or held at finish
   vsls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // arithmetic: two lanes, linear and angular, stepped by the sequencer
   vsls_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .req_linear  (req_ch.linear_request),
      .req_angular (req_ch.angular_request),
      .req_time    (req_ch.time_us),
      .rsp_linear  (rsp_ch.linear_cmd),
      .rsp_angular (rsp_ch.angular_cmd)
   );

   // a second word must wait until the current one is finished
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "word accepted while another is in progress")

   // never overwrite a result that is still waiting
   `ASSERT_IMPLIES(a_load_when_free, clock, reset, cmd.load_out, !rsp_ch.valid || rsp_ch.ready, "result loaded over an untaken word")

   // a loaded result is offered on the next cycle
   `ASSERT_NEXT(a_load_offers, clock, reset, cmd.load_out, rsp_ch.valid, "loaded result not offered")

   // the upper reciprocal half leads straight into the limit step
   `ASSERT_NEXT(a_recip_to_limit, clock, reset, cmd.recip_hi, cmd.limit, "reciprocal did not hand over to limit")

endmodule

// ----- rtl/core/vsls_csr.sv -----
// ----------------------------------------------------------------------------
// vsls_csr
// Configuration registers and their effective, bounded values.
// ----------------------------------------------------------------------------
module vsls_csr import vsls_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output vsls_cfg_type               cfg
);

   logic [19:0] max_lin_ff, max_lin_in;
   logic [19:0] min_lin_ff, min_lin_in;
   logic [19:0] max_ang_ff, max_ang_in;
   logic [19:0] acc_lin_ff, acc_lin_in;
   logic [19:0] acc_ang_ff, acc_ang_in;
   logic [15:0] sm_lin_ff, sm_lin_in;
   logic [15:0] sm_ang_ff, sm_ang_in;
   logic [19:0] slow_ff, slow_in;

   always_comb begin
      max_lin_in = max_lin_ff;
      min_lin_in = min_lin_ff;
      max_ang_in = max_ang_ff;
      acc_lin_in = acc_lin_ff;
      acc_ang_in = acc_ang_ff;
      sm_lin_in  = sm_lin_ff;
      sm_ang_in  = sm_ang_ff;
      slow_in    = slow_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_LINEAR_SPEED:    max_lin_in = csr_data;
            CSR_MIN_LINEAR_SPEED:    min_lin_in = csr_data;
            CSR_MAX_ANGULAR_SPEED:   max_ang_in = csr_data;
            CSR_MAX_LINEAR_ACCEL:    acc_lin_in = csr_data;
            CSR_MAX_ANGULAR_ACCEL:   acc_ang_in = csr_data;
            CSR_LINEAR_SMOOTHING:    sm_lin_in  = csr_data[15:0];
            CSR_ANGULAR_SMOOTHING:   sm_ang_in  = csr_data[15:0];
            CSR_SLOW_TURN_THRESHOLD: slow_in    = csr_data;
            default: ;  // drop writes to unmapped indices
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_lin_ff <= RST_MAX_LINEAR_SPEED;
         min_lin_ff <= RST_MIN_LINEAR_SPEED;
         max_ang_ff <= RST_MAX_ANGULAR_SPEED;
         acc_lin_ff <= RST_MAX_LINEAR_ACCEL;
         acc_ang_ff <= RST_MAX_ANGULAR_ACCEL;
         sm_lin_ff  <= RST_LINEAR_SMOOTHING;
         sm_ang_ff  <= RST_ANGULAR_SMOOTHING;
         slow_ff    <= RST_SLOW_TURN_THRESHOLD;
      end else begin
         max_lin_ff <= max_lin_in;
         min_lin_ff <= min_lin_in;
         max_ang_ff <= max_ang_in;
         acc_lin_ff <= acc_lin_in;
         acc_ang_ff <= acc_ang_in;
         sm_lin_ff  <= sm_lin_in;
         sm_ang_ff  <= sm_ang_in;
         slow_ff    <= slow_in;
      end
   end

   always_comb begin
      cfg.vmax_l = (max_lin_ff < FLOOR_MAX_LINEAR_SPEED) ? FLOOR_MAX_LINEAR_SPEED : max_lin_ff;
      cfg.vmin_l = (min_lin_ff > cfg.vmax_l) ? cfg.vmax_l : min_lin_ff;
      cfg.vmax_a = (max_ang_ff < FLOOR_MAX_ANGULAR_SPEED) ? FLOOR_MAX_ANGULAR_SPEED
                                                         : max_ang_ff;
      cfg.acc_l  = (acc_lin_ff < FLOOR_MAX_LINEAR_ACCEL) ? FLOOR_MAX_LINEAR_ACCEL : acc_lin_ff;
      cfg.acc_a  = (acc_ang_ff < FLOOR_MAX_ANGULAR_ACCEL) ? FLOOR_MAX_ANGULAR_ACCEL
                                                          : acc_ang_ff;
      cfg.sm_l      = (sm_lin_ff > CEIL_SMOOTHING) ? CEIL_SMOOTHING : sm_lin_ff;
      cfg.sm_a      = (sm_ang_ff > CEIL_SMOOTHING) ? CEIL_SMOOTHING : sm_ang_ff;
      cfg.slow_turn = slow_ff;
   end

endmodule

// ----- rtl/core/vsls_ctrl.sv -----
// ----------------------------------------------------------------------------
// vsls_ctrl
// Sequencer: steps one word through multiply, reciprocal, limit, blend, finish.
// ----------------------------------------------------------------------------
module vsls_ctrl import vsls_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output vsls_cmd_type    cmd
);

   vsls_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_RECIP_LO;
         end
         ST_RECIP_LO: begin
            cmd.recip_lo = 1'b1;
            state_in     = ST_RECIP_HI;
         end
         ST_RECIP_HI: begin
            cmd.recip_hi = 1'b1;
            state_in     = ST_LIMIT;
         end
         ST_LIMIT: begin
            cmd.limit = 1'b1;
            state_in  = ST_BLEND;
         end
         ST_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the previous word has left the output
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/vsls_dp.sv -----
// ----------------------------------------------------------------------------
// vsls_dp
// Datapath: elapsed time, step division, slew and speed clamps, blend, floor.
// ----------------------------------------------------------------------------
module vsls_dp import vsls_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  vsls_cmd_type    cmd,
   input  vsls_cfg_type    cfg,
   input  vel_type         req_linear,
   input  vel_type         req_angular,
   input  time_type        req_time,
   output vel_type         rsp_linear,
   output vel_type         rsp_angular
);

   vel_type     lreq_ff, lreq_in;
   vel_type     areq_ff, areq_in;
   logic [31:0] dt_ff, dt_in;
   time_type    last_time_ff, last_time_in;
   vel_type     last_lin_ff, last_lin_in;
   vel_type     last_ang_ff, last_ang_in;
   logic [48:0] diff;

   logic [19:0] lane_acc  [LANES];
   logic [19:0] lane_vmax [LANES];
   logic [15:0] lane_sm   [LANES];
   vel_type     lane_req  [LANES];
   vel_type     lane_prev [LANES];
   vel_type     lane_round[LANES];

   vel_type     lin_r, ang_r, lin_f, ang_f;
   logic [20:0] abs_l, abs_a, vmin_pos, vmin_neg;
   logic        floor_hit;

   // lane 0 carries linear, lane 1 angular
   always_comb begin
      lane_acc[0]  = cfg.acc_l;
      lane_acc[1]  = cfg.acc_a;
      lane_vmax[0] = cfg.vmax_l;
      lane_vmax[1] = cfg.vmax_a;
      lane_sm[0]   = cfg.sm_l;
      lane_sm[1]   = cfg.sm_a;
      lane_req[0]  = lreq_ff;
      lane_req[1]  = areq_ff;
      lane_prev[0] = last_lin_ff;
      lane_prev[1] = last_ang_ff;
   end

   // capture: register the request and the elapsed time
   assign diff = {1'b0, req_time} - {1'b0, last_time_ff};

   always_comb begin
      lreq_in      = lreq_ff;
      areq_in      = areq_ff;
      dt_in        = dt_ff;
      last_time_in = last_time_ff;
      if (cmd.capture) begin
         lreq_in      = req_linear;
         areq_in      = req_angular;
         last_time_in = req_time;
         if (diff[48] || diff[47:0] <= MIN_DT_US) begin
            dt_in = DEFAULT_DT_US;
         end else if (diff[47:0] >= DT_CAP_WIDE) begin
            dt_in = DT_CAP_US;
         end else begin
            dt_in = diff[31:0];
         end
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [51:0]        prod_ff, prod_in;
      logic [72:0]        acc_ff, acc_in;
      logic               sat_ff, sat_in;
      vel_type            lim_ff, lim_in;
      logic signed [37:0] sum_ff, sum_in;
      logic [35:0]        recip_x;
      logic [18:0]        recip_m;
      logic [54:0]        part;
      logic [22:0]        step;
      logic signed [24:0] lo, hi, req_x, vm, t1, t2;
      logic [16:0]        w_new;
      logic signed [37:0] w_prev, w_cur;
      logic [37:0]        biased;

      // divide by 10^6: drop six bits, then multiply by the reciprocal of
      // 15625 in two halves, lower half first
      assign recip_x = prod_ff[41:6];
      assign recip_m = cmd.recip_hi ? RECIP_HI_PART : RECIP_LO_PART;
      assign part    = recip_x * recip_m;

      assign step   = sat_ff ? STEP_CAP : acc_ff[72:50];
      assign req_x  = 25'(lane_req[g]);
      assign lo     = 25'(lane_prev[g]) - $signed({2'b00, step});
      assign hi     = 25'(lane_prev[g]) + $signed({2'b00, step});
      assign vm     = $signed({5'b00000, lane_vmax[g]});
      assign t1     = (req_x < lo) ? lo : ((req_x > hi) ? hi : req_x);
      assign t2     = (t1 < -vm) ? -vm : ((t1 > vm) ? vm : t1);
      assign w_new  = ONE_Q16 - {1'b0, lane_sm[g]};
      assign w_prev = $signed({1'b0, lane_sm[g]}) * lane_prev[g];
      assign w_cur  = $signed({1'b0, w_new}) * lim_ff;
      assign biased = sum_ff + ROUND_BIAS;
      // floor((sum + 2^15) / 2^16), already inside the 21-bit range
      assign lane_round[g] = biased[36:16];

      always_comb begin
         prod_in = prod_ff;
         acc_in  = acc_ff;
         sat_in  = sat_ff;
         lim_in  = lim_ff;
         sum_in  = sum_ff;
         if (cmd.mul) begin
            prod_in = lane_acc[g] * dt_ff;
         end
         if (cmd.recip_lo) begin
            sat_in = (prod_ff >= SAT_PRODUCT);
            acc_in = {18'd0, part};
         end
         if (cmd.recip_hi) begin
            acc_in = acc_ff + {part[53:0], 19'd0};
         end
         if (cmd.limit) begin
            lim_in = t2[20:0];
         end
         if (cmd.blend) begin
            sum_in = w_prev + w_cur;
         end
      end

      always_ff @(posedge clock) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
         sat_ff  <= sat_in;
         lim_ff  <= lim_in;
         sum_ff  <= sum_in;
      end
   end

   // finish: slow-turn floor on linear, then dead zone on both
   always_comb begin
      lin_r     = lane_round[0];
      ang_r     = lane_round[1];
      abs_l     = lin_r[20] ? 21'(~lin_r + 21'sd1) : lin_r;
      abs_a     = ang_r[20] ? 21'(~ang_r + 21'sd1) : ang_r;
      vmin_pos  = {1'b0, cfg.vmin_l};
      vmin_neg  = ~vmin_pos + 21'd1;
      floor_hit = (abs_a < {1'b0, cfg.slow_turn}) && (abs_l >= DEAD_LSB) &&
                  (abs_l < vmin_pos);
      lin_f     = lin_r;
      if (floor_hit) begin
         lin_f = lin_r[20] ? $signed(vmin_neg) : $signed(vmin_pos);
      end
      if (abs_l < DEAD_LSB) begin
         lin_f = '0;
      end
      ang_f = (abs_a < DEAD_LSB) ? '0 : ang_r;
   end

   always_comb begin
      last_lin_in = last_lin_ff;
      last_ang_in = last_ang_ff;
      if (cmd.load_out) begin
         last_lin_in = lin_f;
         last_ang_in = ang_f;
      end
   end

   always_ff @(posedge clock) begin
      lreq_ff <= lreq_in;
      areq_ff <= areq_in;
      dt_ff   <= dt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         last_lin_ff  <= '0;
         last_ang_ff  <= '0;
      end else begin
         last_time_ff <= last_time_in;
         last_lin_ff  <= last_lin_in;
         last_ang_ff  <= last_ang_in;
      end
   end

   // the stored command is also the output word
   assign rsp_linear  = last_lin_ff;
   assign rsp_angular = last_ang_ff;

endmodule

// ----- verif/vsls_cmd_checker.sv -----
// ----------------------------------------------------------------------------
// vsls_cmd_checker
// Watches the request, response and register ports of the slew limiter. Keeps
// its own copy of the registers and of the last command, works out the
// command each accepted request word should give, and compares the response
// words in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vsls_cmd_checker import vsls_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   vsls_req_if                        req_ch,
   vsls_rsp_if                        rsp_ch,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output int                         fail_count,
   output int                         pending_count
);

   typedef struct packed {
      vel_type linear_cmd;
      vel_type angular_cmd;
   } cmd_pair_type;

   localparam longint unsigned SHORT_DT_US   = 64'd1000;
   localparam longint unsigned FALLBACK_DT   = 64'd100000;
   localparam longint unsigned DT_LIMIT      = 64'd1 << 40;
   localparam longint unsigned STEP_LIMIT    = 64'd1 << 22;
   localparam longint unsigned US_PER_SEC    = 64'd1000000;
   localparam longint unsigned LIN_VMAX_LOW  = 64'd655;
   localparam longint unsigned ANG_VMAX_LOW  = 64'd6554;
   localparam longint unsigned LIN_ACC_LOW   = 64'd3277;
   localparam longint unsigned ANG_ACC_LOW   = 64'd6554;
   localparam longint unsigned SMOOTH_HIGH   = 64'd64225;
   localparam longint          DEAD_ZONE     = 64'sd7;
   localparam longint          UNITY_Q16     = 64'sd65536;
   localparam longint          HALF_Q16      = 64'sd32768;
   localparam int              PRINT_LIMIT   = 100;

   logic [19:0]     regs [0:7];
   longint          prev_linear;
   longint          prev_angular;
   longint unsigned prev_time;
   cmd_pair_type    expected_cmds [$];
   int              fails;

   function automatic longint unsigned raise_to(longint unsigned v, longint unsigned lo);
      return (v < lo) ? lo : v;
   endfunction

   function automatic longint unsigned cap_at(longint unsigned v, longint unsigned hi);
      return (v > hi) ? hi : v;
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint step_limit(longint unsigned accel, longint unsigned dt_us);
      return longint'(cap_at(accel * dt_us / US_PER_SEC, STEP_LIMIT));
   endfunction

   // slew around the last command, clamp to speed, blend with the last command
   function automatic longint slew_blend(longint req, longint prev, longint step,
                                         longint vmax, longint smooth);
      longint t;
      longint sum;
      t = req;
      if (t < prev - step) t = prev - step;
      if (t > prev + step) t = prev + step;
      if (t < -vmax) t = -vmax;
      if (t > vmax) t = vmax;
      sum = smooth * prev + (UNITY_Q16 - smooth) * t;
      return (sum + HALF_Q16) >>> 16;
   endfunction

   function automatic cmd_pair_type predict_cmd(vel_type lin_req, vel_type ang_req,
                                                time_type now);
      longint unsigned vmax_l, vmin_l, vmax_a, acc_l, acc_a, sm_l, sm_a, dt;
      longint          lin, ang;
      vel_type         lin_out, ang_out;
      cmd_pair_type    cmd;
      vmax_l = raise_to(regs[CSR_MAX_LINEAR_SPEED], LIN_VMAX_LOW);
      vmin_l = cap_at(regs[CSR_MIN_LINEAR_SPEED], vmax_l);
      vmax_a = raise_to(regs[CSR_MAX_ANGULAR_SPEED], ANG_VMAX_LOW);
      acc_l  = raise_to(regs[CSR_MAX_LINEAR_ACCEL], LIN_ACC_LOW);
      acc_a  = raise_to(regs[CSR_MAX_ANGULAR_ACCEL], ANG_ACC_LOW);
      sm_l   = cap_at(regs[CSR_LINEAR_SMOOTHING], SMOOTH_HIGH);
      sm_a   = cap_at(regs[CSR_ANGULAR_SMOOTHING], SMOOTH_HIGH);

      if (64'(now) < prev_time) begin
         dt = FALLBACK_DT;
      end else begin
         dt = 64'(now) - prev_time;
         if (dt <= SHORT_DT_US) dt = FALLBACK_DT;
         dt = cap_at(dt, DT_LIMIT);
      end

      lin = slew_blend(longint'(lin_req), prev_linear, step_limit(acc_l, dt),
                       longint'(vmax_l), longint'(sm_l));
      ang = slew_blend(longint'(ang_req), prev_angular, step_limit(acc_a, dt),
                       longint'(vmax_a), longint'(sm_a));

      // lift a slow creep to the minimum speed while barely turning
      if (magnitude(ang) < longint'(regs[CSR_SLOW_TURN_THRESHOLD]) &&
          magnitude(lin) >= DEAD_ZONE && magnitude(lin) < longint'(vmin_l)) begin
         lin = (lin < 0) ? -longint'(vmin_l) : longint'(vmin_l);
      end
      if (magnitude(lin) < DEAD_ZONE) lin = 0;
      if (magnitude(ang) < DEAD_ZONE) ang = 0;

      lin_out      = lin[20:0];
      ang_out      = ang[20:0];
      prev_linear  = longint'(lin_out);
      prev_angular = longint'(ang_out);
      prev_time    = 64'(now);
      cmd.linear_cmd  = lin_out;
      cmd.angular_cmd = ang_out;
      return cmd;
   endfunction

   task automatic report_failure(string msg);
      if (fails < PRINT_LIMIT) $display("[%0t] MISMATCH %s", $realtime, msg);
      fails++;
   endtask

   always @(posedge clock) begin
      cmd_pair_type want;
      if (reset) begin
         regs[CSR_MAX_LINEAR_SPEED]    = 20'd32768;
         regs[CSR_MIN_LINEAR_SPEED]    = 20'd3277;
         regs[CSR_MAX_ANGULAR_SPEED]   = 20'd65536;
         regs[CSR_MAX_LINEAR_ACCEL]    = 20'd32768;
         regs[CSR_MAX_ANGULAR_ACCEL]   = 20'd65536;
         regs[CSR_LINEAR_SMOOTHING]    = 20'd0;
         regs[CSR_ANGULAR_SMOOTHING]   = 20'd0;
         regs[CSR_SLOW_TURN_THRESHOLD] = 20'd26214;
         prev_linear  = 0;
         prev_angular = 0;
         prev_time    = 0;
         expected_cmds.delete();
      end else begin
         // indexes past the map are dropped; smoothing keeps 16 bits
         if (csr_write_enable && csr_index <= CSR_SLOW_TURN_THRESHOLD) begin
            if (csr_index == CSR_LINEAR_SMOOTHING || csr_index == CSR_ANGULAR_SMOOTHING)
               regs[csr_index[2:0]] = {4'd0, csr_data[15:0]};
            else
               regs[csr_index[2:0]] = csr_data;
         end
         if (req_ch.valid && req_ch.ready)
            expected_cmds.push_back(predict_cmd(req_ch.linear_request,
                                                req_ch.angular_request, req_ch.time_us));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_cmds.size() == 0) begin
               report_failure($sformatf("unexpected word linear=%0d angular=%0d",
                                        rsp_ch.linear_cmd, rsp_ch.angular_cmd));
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_ch.linear_cmd !== want.linear_cmd)
                  report_failure($sformatf("linear_cmd got %0d want %0d",
                                           rsp_ch.linear_cmd, want.linear_cmd));
               if (rsp_ch.angular_cmd !== want.angular_cmd)
                  report_failure($sformatf("angular_cmd got %0d want %0d",
                                           rsp_ch.angular_cmd, want.angular_cmd));
            end
         end
      end
      fail_count    <= fails;
      pending_count <= expected_cmds.size();
   end

   initial fails = 0;

endmodule

// ----- verif/velocity_slew_limit_smoother_top_tb.sv -----
// ----------------------------------------------------------------------------
// velocity_slew_limit_smoother_top_tb
// Drives request words and register writes into the slew limiter, stalls the
// response side at random and lets the command checker judge every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module velocity_slew_limit_smoother_top_tb;
   import vsls_pkg::*;

   localparam vel_type VEL_MAX     = 21'h0F_FFFF;
   localparam vel_type VEL_MIN     = 21'h10_0000;
   localparam int      QUIET_LIMIT = 3000;   // cycles with no word moving
   localparam int      PHASE_WORDS = 300;
   localparam int      PHASES      = 6;
   localparam int      SETTLE      = 40;     // longer than one word's turnaround

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;
   int                         fail_count;
   int                         pending_count;
   int                         send_idle_pct;
   int                         recv_idle_pct;
   int                         quiet_cycles;
   vel_type                    last_lin_req;
   vel_type                    last_ang_req;
   time_type                   stamp_now;

   vsls_req_if req_ch ();
   vsls_rsp_if rsp_ch ();

   velocity_slew_limit_smoother_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   vsls_cmd_checker cmd_check (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offer one word, at times after a random gap. Valid is left high after the
   // handshake so that back-to-back words keep it up without a glitch.
   task automatic send_word(vel_type lin, vel_type ang, time_type stamp);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.linear_request  <= lin;
      req_ch.angular_request <= ang;
      req_ch.time_us         <= stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      last_lin_req = lin;
      last_ang_req = ang;
      stamp_now    = stamp;
   endtask

   // Drop valid and hold until every command owed has come back. Wait for a
   // clock edge first so the count already holds the word just accepted.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Write the whole register map, then one stray index past its end, which
   // the block must ignore. Enable stays high across the burst.
   task automatic program_setting(int phase);
      logic [19:0] vals [0:7];
      case (phase)
         0: begin
            // all zero: every floor on the limits takes over
            foreach (vals[i]) vals[i] = 20'd0;
         end
         1: begin
            // all ones: smoothing capped, minimum speed capped at maximum
            foreach (vals[i]) vals[i] = 20'hF_FFFF;
         end
         2: begin
            vals[CSR_MAX_LINEAR_SPEED]    = 20'd65536;
            vals[CSR_MIN_LINEAR_SPEED]    = 20'd3277;
            vals[CSR_MAX_ANGULAR_SPEED]   = 20'd131072;
            vals[CSR_MAX_LINEAR_ACCEL]    = 20'd49152;
            vals[CSR_MAX_ANGULAR_ACCEL]   = 20'd98304;
            vals[CSR_LINEAR_SMOOTHING]    = 20'd32768;
            vals[CSR_ANGULAR_SMOOTHING]   = 20'd49152;
            vals[CSR_SLOW_TURN_THRESHOLD] = 20'd26214;
         end
         3: begin
            vals[CSR_MAX_LINEAR_SPEED]    = 20'($urandom_range(655, 200000));
            vals[CSR_MIN_LINEAR_SPEED]    = 20'($urandom_range(0, vals[CSR_MAX_LINEAR_SPEED]));
            vals[CSR_MAX_ANGULAR_SPEED]   = 20'($urandom_range(6554, 400000));
            vals[CSR_MAX_LINEAR_ACCEL]    = 20'($urandom_range(3277, 300000));
            vals[CSR_MAX_ANGULAR_ACCEL]   = 20'($urandom_range(6554, 600000));
            vals[CSR_LINEAR_SMOOTHING]    = 20'($urandom_range(0, 64225));
            vals[CSR_ANGULAR_SMOOTHING]   = 20'($urandom_range(0, 64225));
            vals[CSR_SLOW_TURN_THRESHOLD] = 20'($urandom_range(0, 200000));
         end
         4: begin
            // minimum above maximum, heaviest smoothing, floor always armed
            vals[CSR_MAX_LINEAR_SPEED]    = 20'd1000;
            vals[CSR_MIN_LINEAR_SPEED]    = 20'd50000;
            vals[CSR_MAX_ANGULAR_SPEED]   = 20'd6554;
            vals[CSR_MAX_LINEAR_ACCEL]    = 20'd3277;
            vals[CSR_MAX_ANGULAR_ACCEL]   = 20'd6554;
            vals[CSR_LINEAR_SMOOTHING]    = 20'd64225;
            vals[CSR_ANGULAR_SMOOTHING]   = 20'd64225;
            vals[CSR_SLOW_TURN_THRESHOLD] = 20'hF_FFFF;
         end
         default: begin
            foreach (vals[i]) vals[i] = 20'($urandom);
         end
      endcase
      for (int idx = CSR_MAX_LINEAR_SPEED; idx <= CSR_SLOW_TURN_THRESHOLD; idx++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_INDEX_WIDTH'(idx);
         csr_data         <= vals[idx];
         @(posedge clock);
      end
      csr_index <= CSR_SLOW_TURN_THRESHOLD + CSR_INDEX_WIDTH'($urandom_range(1, 8));
      csr_data  <= 20'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mix of full-range noise, creep near zero (dead zone and floor), slow
   // ramps around the last request, moderate speeds and the field extremes.
   function automatic vel_type pick_velocity(vel_type prev);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) return vel_type'($urandom);
      if (pick < 45) return vel_type'(int'($urandom_range(0, 40)) - 20);
      if (pick < 70) return prev + vel_type'(int'($urandom_range(0, 4000)) - 2000);
      if (pick < 90) return vel_type'(int'($urandom_range(0, 140000)) - 70000);
      case ($urandom_range(0, 3))
         0: return VEL_MAX;
         1: return VEL_MIN;
         2: return -VEL_MAX;
         default: return vel_type'(0);
      endcase
   endfunction

   // Mostly plausible control intervals; now and then a short one, a step
   // backwards, a long jump or a time anywhere in the 48-bit range.
   function automatic time_type pick_stamp(time_type prev);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return prev + time_type'($urandom_range(1001, 250000));
      if (pick < 88) return prev + time_type'($urandom_range(0, 1000));
      if (pick < 92) return prev - time_type'($urandom_range(1, 5000));
      if (pick < 96) return prev + {8'd0, 8'($urandom), 32'($urandom)};
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic run_directed();
      time_type t;
      send_word('0, '0, 48'd0);                 // no time elapsed: fallback interval
      send_word(VEL_MAX, VEL_MAX, 48'd500);     // short interval
      send_word(VEL_MIN, VEL_MIN, 48'd1500);    // exactly the minimum interval
      send_word(VEL_MAX, VEL_MIN, 48'd2501);    // one microsecond over it
      send_word(21'sd100000, 21'sd50000, 48'd2000);   // time runs backwards
      send_word(VEL_MAX, VEL_MAX, '1);          // huge interval: step saturates
      send_word(VEL_MIN, VEL_MAX, '1);          // zero interval at the top of time
      send_word('0, '0, 48'd0);                 // back to the very start
      t = 48'd2_000_000_000;
      send_word('0, '0, t);                     // settle both channels to zero
      t += 48'd1_000_000;
      send_word(21'sd6, -21'sd6, t);            // both inside the dead zone
      t += 48'd1_000_000;
      send_word(21'sd7, 21'sd7, t);             // creep lifted to minimum speed
      t += 48'd1_000_000;
      send_word(-21'sd7, 21'sd30000, t);        // turning fast: no lift
      t += 48'd1_000_000;
      send_word(-21'sd100, 21'sd0, t);          // negative creep lifted
      t += 48'd1_000_000;
      send_word(-21'sd1, 21'sd1, t);            // dead zone beats the lift
      t += (48'd1 << 40) + 48'd5;
      send_word(VEL_MIN, VEL_MAX, t);           // far past the interval cap
      t += 48'd1001;
      send_word(VEL_MAX, -VEL_MAX, t);
   endtask

   // Response side: hold ready for random runs; idle share set per phase.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         repeat ($urandom_range(0, 5)) @(posedge clock);
      end
   end

   // Watchdog: end the run if no word moves on either channel for too long.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.linear_request  <= '0;
      req_ch.angular_request <= '0;
      req_ch.time_us         <= '0;
      csr_write_enable       <= 1'b0;
      csr_index              <= CSR_MAX_LINEAR_SPEED;
      csr_data               <= '0;
      send_idle_pct = 25;
      recv_idle_pct = 62;
      last_lin_req  = '0;
      last_ang_req  = '0;
      stamp_now     = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed words under the reset register values
      run_directed();
      drain();

      // random phases: idle shares swap after the first third, the last third runs flat out
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 2) begin
            send_idle_pct = 25;
            recv_idle_pct = 62;
         end else if (phase < 4) begin
            send_idle_pct = 62;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         program_setting(phase);
         repeat (PHASE_WORDS)
            send_word(pick_velocity(last_lin_req), pick_velocity(last_ang_req),
                      pick_stamp(stamp_now));
         drain();
      end

      // let any stray word surface before the verdict
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
